@@ hw/rtl/gbse_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbse_pkg
// Shared types and constants for the Gaussian blur / Sobel edge core.
// ----------------------------------------------------------------------------
package gbse_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RAW,
        S_SUM,
        S_DIV,
        S_FIX,
        S_SOB,
        S_SQ,
        S_SQRT,
        S_OUT
    } t_state;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    localparam logic [3:0] GAUSS [5][5] = '{
        '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
        '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
        '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
    };

    // floor(2^23 / 159); quotient comes out exact or one low
    localparam logic [15:0] RECIP_159 = 16'd52758;
    localparam logic [15:0] DIVISOR   = 16'd159;

endpackage

`default_nettype wire

@@ hw/rtl/gaussian_blur_sobel_edge_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_blur_sobel_edge_core
// Streaming 5x5 Gaussian blur (weights /159) and 3x3 Sobel magnitude.
// ----------------------------------------------------------------------------
// Input beats (i_valid/o_ready) carry i_op and i_pixel in raster order; op 1
// is a drain beat. Result beats (o_valid/i_ready) carry the blurred value,
// the gradient magnitude (0 on the frame border) and o_frame_end on the last
// position. Result n appears on input beat n+3*W+3, so after W*H pixels the
// host sends 3*W+3 drain beats. Writes on the config port restart the frame.
// One beat is worked at a time by a sequencer around two column-indexed line
// memories (4 raw lines and 2 blurred lines packed per word, registered read).
// A beat before any blur position only updates the raw line; a beat with a
// blur position adds the row-wise blur sum and reciprocal divide, and one
// with a result Sobel, square sum, 8-step bit-serial root and output load.
// A finished result sits in the output register, and the next input beat is
// taken while it waits; a stalled receiver holds the sequencer only when a
// second result is ready. Reset clears control state and windows; the line
// memories need no clearing, since out-of-frame taps are masked by position.
// ----------------------------------------------------------------------------
module gaussian_blur_sobel_edge_core
    import gbse_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_pixel,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_blurred,
    output logic [7:0]       o_edge_res,
    output logic             o_frame_end
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 3);
    localparam int HW = $clog2(MAX_HEIGHT + 6);

    t_state r_state, n_state;

    logic [10:0] r_fw, r_fh;
    logic [WW-1:0] w_w;
    logic [HW-1:0] w_h;

    always_comb begin
        if (r_fw < 11'd3) w_w = WW'(3);
        else if (32'(r_fw) > MAX_WIDTH) w_w = WW'(MAX_WIDTH);
        else w_w = WW'(r_fw);
        if (r_fh < 11'd3) w_h = HW'(3);
        else if (32'(r_fh) > MAX_HEIGHT) w_h = HW'(MAX_HEIGHT);
        else w_h = HW'(r_fh);
    end

    // position counters
    logic [WW-1:0] r_kc, r_bc, r_ec;
    logic [HW-1:0] r_kr, r_br, r_er;
    logic          r_b_on, r_e_on;

    // latched job of the beat in flight
    logic [WW-1:0] r_j_kc, r_j_bc, r_j_ec;
    logic [HW-1:0] r_j_br, r_j_er;
    logic          r_j_b, r_j_e, r_j_last;
    logic [7:0]    r_j_pix;

    logic          w_acc, w_b_now, w_e_now, w_last;
    logic [WW-1:0] w_bc, w_ec;
    logic [HW-1:0] w_br, w_er;

    assign w_acc   = i_valid && o_ready;
    assign w_b_now = r_b_on || (r_kr == HW'(2) && r_kc == WW'(2));
    assign w_bc    = r_b_on ? r_bc : '0;
    assign w_br    = r_b_on ? r_br : '0;
    assign w_e_now = w_b_now && (r_e_on || (w_br == HW'(1) && w_bc == WW'(1)));
    assign w_ec    = r_e_on ? r_ec : '0;
    assign w_er    = r_e_on ? r_er : '0;
    assign w_last  = w_e_now && (w_er == w_h - HW'(1)) && (w_ec == w_w - WW'(1));

    // line memories
    logic [31:0] raw_mem [MAX_WIDTH];
    logic [15:0] blur_mem [MAX_WIDTH];
    logic [31:0] r_raw_rd;
    logic [15:0] r_blur_rd;
    logic        w_raw_we, w_blur_re, w_blur_we;
    logic [7:0]  w_bv;

    assign w_raw_we  = (r_state == S_RAW);
    assign w_blur_re = (r_state == S_RAW) && r_j_b;
    assign w_blur_we = (r_state == S_FIX);

    always_ff @(posedge i_clk) begin
        if (w_raw_we) raw_mem[r_j_kc[AW-1:0]] <= {r_raw_rd[23:0], r_j_pix};
        if (w_acc) r_raw_rd <= raw_mem[r_kc[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_blur_we) blur_mem[r_j_bc[AW-1:0]] <= {r_blur_rd[7:0], w_bv};
        if (w_blur_re) r_blur_rd <= blur_mem[r_j_bc[AW-1:0]];
    end

    // windows and datapath
    logic [7:0]  r_rwin [5][5];
    logic [7:0]  r_bwin [3][3];
    logic [4:0]  r_rmask, r_cmask;
    logic [2:0]  r_sr;
    logic [15:0] r_sum;
    logic [31:0] r_prod;
    logic signed [11:0] r_gx, r_gy;
    logic [21:0] r_s;
    logic [7:0]  r_rt;
    logic [2:0]  r_bit;

    logic [15:0] w_row_sum;
    logic [7:0]  w_q0;
    logic [15:0] w_rem;
    logic signed [11:0] w_gx, w_gy;
    logic [7:0]  w_try;
    logic [15:0] w_try_sq;
    logic [7:0]  w_edge;
    logic        w_inner;

    always_comb begin
        w_row_sum = '0;
        for (int dx = 0; dx < 5; dx++) begin
            if (r_cmask[dx])
                w_row_sum = w_row_sum + 16'(r_rwin[r_sr][dx] * GAUSS[r_sr][dx]);
        end
    end

    assign w_q0  = r_prod[30:23];
    assign w_rem = r_sum - 16'(w_q0) * DIVISOR;
    assign w_bv  = w_q0 + 8'(w_rem >= DIVISOR);

    assign w_gx = 12'(r_bwin[0][2]) + 12'(r_bwin[1][2]) * 12'sd2 + 12'(r_bwin[2][2])
                - 12'(r_bwin[0][0]) - 12'(r_bwin[1][0]) * 12'sd2 - 12'(r_bwin[2][0]);
    assign w_gy = 12'(r_bwin[2][0]) + 12'(r_bwin[2][1]) * 12'sd2 + 12'(r_bwin[2][2])
                - 12'(r_bwin[0][0]) - 12'(r_bwin[0][1]) * 12'sd2 - 12'(r_bwin[0][2]);

    assign w_try    = r_rt | (8'd1 << r_bit);
    assign w_try_sq = 16'(w_try) * 16'(w_try);

    assign w_inner = (r_j_er != '0) && (r_j_er != w_h - HW'(1))
                  && (r_j_ec != '0) && (r_j_ec != w_w - WW'(1));
    assign w_edge  = !w_inner ? 8'd0 : ((r_s >= 22'd65536) ? 8'd255 : r_rt);

    // next state
    logic w_load;

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = S_RAW;
            end
            S_RAW:  n_state = r_j_b ? S_SUM : S_IDLE;
            S_SUM:  if (r_sr == 3'd4) n_state = S_DIV;
            S_DIV:  n_state = S_FIX;
            S_FIX:  n_state = r_j_e ? S_SOB : S_IDLE;
            S_SOB:  n_state = S_SQ;
            S_SQ:   n_state = S_SQRT;
            S_SQRT: if (r_bit == 3'd0) n_state = S_OUT;
            S_OUT: begin
                if (!o_valid || i_ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // config and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw   <= 11'd1024;
            r_fh   <= 11'd1024;
            r_kc   <= '0;
            r_kr   <= '0;
            r_bc   <= '0;
            r_br   <= '0;
            r_ec   <= '0;
            r_er   <= '0;
            r_b_on <= 1'b0;
            r_e_on <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_WIDTH) r_fw <= i_cfg_data;
            else r_fh <= i_cfg_data;
            r_kc   <= '0;
            r_kr   <= '0;
            r_b_on <= 1'b0;
            r_e_on <= 1'b0;
        end else if (w_acc) begin
            if (w_last) begin
                r_kc   <= '0;
                r_kr   <= '0;
                r_b_on <= 1'b0;
                r_e_on <= 1'b0;
            end else begin
                if (r_kc == w_w - WW'(1)) begin
                    r_kc <= '0;
                    r_kr <= r_kr + HW'(1);
                end else begin
                    r_kc <= r_kc + WW'(1);
                end
                r_b_on <= w_b_now;
                r_e_on <= w_e_now;
                if (w_b_now) begin
                    if (w_bc == w_w - WW'(1)) begin
                        r_bc <= '0;
                        r_br <= w_br + HW'(1);
                    end else begin
                        r_bc <= w_bc + WW'(1);
                        r_br <= w_br;
                    end
                end
                if (w_e_now) begin
                    if (w_ec == w_w - WW'(1)) begin
                        r_ec <= '0;
                        r_er <= w_er + HW'(1);
                    end else begin
                        r_ec <= w_ec + WW'(1);
                        r_er <= w_er;
                    end
                end
            end
        end
    end

    // job latch
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_j_kc   <= r_kc;
            r_j_bc   <= w_bc;
            r_j_br   <= w_br;
            r_j_ec   <= w_ec;
            r_j_er   <= w_er;
            r_j_b    <= w_b_now;
            r_j_e    <= w_e_now;
            r_j_last <= w_last;
            r_j_pix  <= (!i_op && r_kr < w_h) ? i_pixel : 8'd0;
        end
    end

    // windows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int y = 0; y < 5; y++)
                for (int x = 0; x < 5; x++) r_rwin[y][x] <= '0;
            for (int y = 0; y < 3; y++)
                for (int x = 0; x < 3; x++) r_bwin[y][x] <= '0;
        end else begin
            if (r_state == S_RAW) begin
                for (int y = 0; y < 5; y++)
                    for (int x = 0; x < 4; x++) r_rwin[y][x] <= r_rwin[y][x+1];
                r_rwin[0][4] <= r_raw_rd[31:24];
                r_rwin[1][4] <= r_raw_rd[23:16];
                r_rwin[2][4] <= r_raw_rd[15:8];
                r_rwin[3][4] <= r_raw_rd[7:0];
                r_rwin[4][4] <= r_j_pix;
            end
            if (r_state == S_FIX) begin
                for (int y = 0; y < 3; y++)
                    for (int x = 0; x < 2; x++) r_bwin[y][x] <= r_bwin[y][x+1];
                r_bwin[0][2] <= r_blur_rd[15:8];
                r_bwin[1][2] <= r_blur_rd[7:0];
                r_bwin[2][2] <= w_bv;
            end
        end
    end

    // arithmetic steps
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_RAW: begin
                r_sr  <= '0;
                r_sum <= '0;
                for (int d = 0; d < 5; d++) begin
                    r_rmask[d] <= ((32'(r_j_br) + d) >= 2)
                               && ((32'(r_j_br) + d) < (32'(w_h) + 2));
                    r_cmask[d] <= ((32'(r_j_bc) + d) >= 2)
                               && ((32'(r_j_bc) + d) < (32'(w_w) + 2));
                end
            end
            S_SUM: begin
                if (r_rmask[r_sr]) r_sum <= r_sum + w_row_sum;
                r_sr <= r_sr + 3'd1;
            end
            S_DIV:  r_prod <= 32'(r_sum) * 32'(RECIP_159);
            S_SOB: begin
                r_gx <= w_gx;
                r_gy <= w_gy;
            end
            S_SQ: begin
                r_s   <= 22'(r_gx * r_gx) + 22'(r_gy * r_gy);
                r_rt  <= '0;
                r_bit <= 3'd7;
            end
            S_SQRT: begin
                if (w_try_sq <= r_s[15:0]) r_rt <= w_try;
                r_bit <= r_bit - 3'd1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_load) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_blurred   <= r_bwin[1][1];
            o_edge_res  <= w_edge;
            o_frame_end <= r_j_last;
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == S_IDLE))
        else $error("ready outside idle");
    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_OUT))
        else $error("result loaded outside output step");
    a_e_after_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_on |-> r_b_on)
        else $error("edge position active before blur position");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_cfg_we) |-> (r_kc < w_w))
        else $error("column counter out of range");
`endif

endmodule

`default_nettype wire
